### rtl/mstt_pkg.sv
// Shared types and constants for the multi-slot tick timer table.
package mstt_pkg;

	localparam int SLOT_COUNT = 8;
	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	localparam int OP_W = 2;
	localparam int ID_W = 8;
	localparam int PERIOD_W = 16;
	localparam int STATUS_W = 2;
	localparam int EXP_SLOT_W = 3;

	typedef enum logic [OP_W-1:0] {
		OP_TICK     = 2'd0,
		OP_START    = 2'd1,
		OP_REGISTER = 2'd2,
		OP_CANCEL   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK       = 2'd0,
		STS_FULL     = 2'd1,
		STS_DUP      = 2'd2,
		STS_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic tick_op;
		logic cur_expire;
		logic pend_valid;
		logic last_idx;
		logic out_full;
	} stat_t;

endpackage

### rtl/mstt_req_if.sv
// Request channel: operation, client id and period with valid/ready.
interface mstt_req_if;
	logic                          valid;
	logic                          ready;
	logic [mstt_pkg::OP_W-1:0]     operation;
	logic [mstt_pkg::ID_W-1:0]     client_id;
	logic [mstt_pkg::PERIOD_W-1:0] period_ticks;

	modport source (output valid, output operation, output client_id, output period_ticks,
		input ready);
	modport sink (input valid, input operation, input client_id, input period_ticks,
		output ready);
endinterface

### rtl/mstt_rsp_if.sv
// Result channel: status and expiry report with valid/ready.
interface mstt_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [mstt_pkg::STATUS_W-1:0]   status;
	logic                            expired;
	logic [mstt_pkg::ID_W-1:0]       expired_id;
	logic [mstt_pkg::EXP_SLOT_W-1:0] expired_slot;
	logic                            last;

	modport source (output valid, output status, output expired, output expired_id,
		output expired_slot, output last, input ready);
	modport sink (input valid, input status, input expired, input expired_id,
		input expired_slot, input last, output ready);
endinterface

### rtl/mstt_ctrl.sv
// Controller state machine: accept, slot scan and final result.
module mstt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  mstt_pkg::stat_t stat,
	output mstt_pkg::cmd_t  cmd,
	output mstt_pkg::state_t state
);

	mstt_pkg::state_t state_q;
	mstt_pkg::state_t state_d;
	logic             stall;

	assign state = state_q;
	assign stall = stat.tick_op && stat.cur_expire && stat.pend_valid && stat.out_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mstt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mstt_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = mstt_pkg::S_SCAN;
				end
			end
			mstt_pkg::S_SCAN: begin
				if (!stall && stat.last_idx) begin
					state_d = mstt_pkg::S_FINISH;
				end
			end
			mstt_pkg::S_FINISH: begin
				if (!stat.out_full) begin
					state_d = mstt_pkg::S_IDLE;
				end
			end
			default: state_d = mstt_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req_ready  = 1'b0;
		cmd        = '0;
		unique case (state_q)
			mstt_pkg::S_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			mstt_pkg::S_SCAN: begin
				cmd.step = !stall;
			end
			mstt_pkg::S_FINISH: begin
				cmd.finish = !stat.out_full;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

### rtl/mstt_dp.sv
// Datapath: slot table, scan registers and result register.
module mstt_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mstt_pkg::cmd_t                  cmd,
	output mstt_pkg::stat_t                 stat,
	input  logic [mstt_pkg::OP_W-1:0]       operation,
	input  logic [mstt_pkg::ID_W-1:0]       client_id,
	input  logic [mstt_pkg::PERIOD_W-1:0]   period_ticks,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output logic [mstt_pkg::STATUS_W-1:0]   status,
	output logic                            expired,
	output logic [mstt_pkg::ID_W-1:0]       expired_id,
	output logic [mstt_pkg::EXP_SLOT_W-1:0] expired_slot,
	output logic                            last
);

	localparam int N = mstt_pkg::SLOT_COUNT;
	localparam int SW = mstt_pkg::SLOT_W;

	logic [mstt_pkg::ID_W-1:0]     owner_q     [N];
	logic                          one_shot_q  [N];
	logic [mstt_pkg::PERIOD_W-1:0] period_tbl_q[N];
	logic [mstt_pkg::PERIOD_W-1:0] ticks_q     [N];

	mstt_pkg::op_t                 op_q;
	logic [mstt_pkg::ID_W-1:0]     id_q;
	logic [mstt_pkg::PERIOD_W-1:0] period_q;
	logic [SW-1:0]                 idx_q;
	logic                          free_found_q;
	logic [SW-1:0]                 free_idx_q;
	logic                          match_found_q;
	logic [SW-1:0]                 match_idx_q;
	logic                          pend_valid_q;
	logic [mstt_pkg::ID_W-1:0]     pend_id_q;
	logic [mstt_pkg::EXP_SLOT_W-1:0] pend_slot_q;

	logic                            out_valid_q;
	mstt_pkg::status_t               out_status_q;
	logic                            out_expired_q;
	logic [mstt_pkg::ID_W-1:0]       out_id_q;
	logic [mstt_pkg::EXP_SLOT_W-1:0] out_slot_q;
	logic                            out_last_q;

	logic [mstt_pkg::ID_W-1:0]     cur_owner;
	logic                          cur_busy;
	logic [mstt_pkg::PERIOD_W-1:0] cur_tnext;
	logic                          cur_expire;
	logic                          tick_op;
	logic                          step_tick;
	logic                          push_pend;
	logic                          take_ok;
	logic                          take_one_shot;
	mstt_pkg::status_t             fin_status;

	assign cur_owner  = owner_q[idx_q];
	assign cur_busy   = (cur_owner != '0);
	assign cur_tnext  = ticks_q[idx_q] + mstt_pkg::PERIOD_W'(1);
	assign cur_expire = cur_busy && (cur_tnext >= period_tbl_q[idx_q]);
	assign tick_op    = (op_q == mstt_pkg::OP_TICK);
	assign step_tick  = cmd.step && tick_op;
	assign push_pend  = step_tick && cur_expire && pend_valid_q;

	assign stat.tick_op    = tick_op;
	assign stat.cur_expire = cur_expire;
	assign stat.pend_valid = pend_valid_q;
	assign stat.last_idx   = (idx_q == SW'(N - 1));
	assign stat.out_full   = out_valid_q && !rsp_ready;

	always_comb begin
		take_ok       = 1'b0;
		take_one_shot = 1'b0;
		fin_status    = mstt_pkg::STS_OK;
		unique case (op_q)
			mstt_pkg::OP_TICK: begin
				fin_status = mstt_pkg::STS_OK;
			end
			mstt_pkg::OP_START: begin
				take_ok       = free_found_q;
				take_one_shot = 1'b1;
				fin_status    = free_found_q ? mstt_pkg::STS_OK : mstt_pkg::STS_FULL;
			end
			mstt_pkg::OP_REGISTER: begin
				take_ok = free_found_q && !match_found_q;
				if (match_found_q) begin
					fin_status = mstt_pkg::STS_DUP;
				end else if (free_found_q) begin
					fin_status = mstt_pkg::STS_OK;
				end else begin
					fin_status = mstt_pkg::STS_FULL;
				end
			end
			mstt_pkg::OP_CANCEL: begin
				fin_status = match_found_q ? mstt_pkg::STS_OK : mstt_pkg::STS_NOTFOUND;
			end
			default: fin_status = mstt_pkg::STS_OK;
		endcase
	end

	// slot owners: free on reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				owner_q[i] <= '0;
			end
		end else if (step_tick && cur_expire && one_shot_q[idx_q]) begin
			owner_q[idx_q] <= '0;
		end else if (cmd.finish && take_ok) begin
			owner_q[free_idx_q] <= id_q;
		end else if (cmd.finish && op_q == mstt_pkg::OP_CANCEL && match_found_q) begin
			owner_q[match_idx_q] <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_tick && cur_busy) begin
			ticks_q[idx_q] <= cur_expire ? '0 : cur_tnext;
		end else if (cmd.finish && take_ok) begin
			ticks_q[free_idx_q]      <= '0;
			period_tbl_q[free_idx_q] <= period_q;
			one_shot_q[free_idx_q]   <= take_one_shot;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q          <= mstt_pkg::op_t'(operation);
			id_q          <= client_id;
			period_q      <= period_ticks;
			idx_q         <= '0;
			free_found_q  <= 1'b0;
			match_found_q <= 1'b0;
		end else if (cmd.step) begin
			idx_q <= idx_q + SW'(1);
			if (!free_found_q && cur_owner == '0) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_q;
			end
			if (!match_found_q && cur_owner == id_q) begin
				match_found_q <= 1'b1;
				match_idx_q   <= idx_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.load) begin
			pend_valid_q <= 1'b0;
		end else if (step_tick && cur_expire) begin
			pend_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_tick && cur_expire) begin
			pend_id_q   <= cur_owner;
			pend_slot_q <= mstt_pkg::EXP_SLOT_W'(idx_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_pend || cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// earlier expiry goes out once a later one shows it was not the last
	always_ff @(posedge clk) begin
		if (push_pend) begin
			out_status_q  <= mstt_pkg::STS_OK;
			out_expired_q <= 1'b1;
			out_id_q      <= pend_id_q;
			out_slot_q    <= pend_slot_q;
			out_last_q    <= 1'b0;
		end else if (cmd.finish) begin
			out_status_q  <= fin_status;
			out_expired_q <= tick_op && pend_valid_q;
			out_id_q      <= (tick_op && pend_valid_q) ? pend_id_q : '0;
			out_slot_q    <= (tick_op && pend_valid_q) ? pend_slot_q : '0;
			out_last_q    <= 1'b1;
		end
	end

	assign rsp_valid    = out_valid_q;
	assign status       = out_status_q;
	assign expired      = out_expired_q;
	assign expired_id   = out_id_q;
	assign expired_slot = out_slot_q;
	assign last         = out_last_q;

endmodule

### rtl/multi_slot_tick_timer_table_core.sv
// Top level of the multi-slot tick timer table.
// A table of SLOT_COUNT timer slots serves tick, start one-shot, register periodic and
// cancel requests. Every request walks the table one slot per clock unless the scan is
// held, and goes from acceptance through the slot scan to a commit step that writes its
// final result; a tick holds the scan while an earlier expiry report waits in the
// result register and a further slot expires, and the commit step waits until the result
// register is free. A tick yields one result per expiring slot in slot order, the
// final one marked last, or a single empty result when nothing expires; the other
// requests yield one status result. Slot owners are cleared by reset.
module multi_slot_tick_timer_table_core (
	input logic      clk,
	input logic      arst_n,
	mstt_req_if.sink   req,
	mstt_rsp_if.source rsp
);

	mstt_pkg::cmd_t   cmd;
	mstt_pkg::stat_t  stat;
	mstt_pkg::state_t state;

	mstt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd),
		.state     (state)
	);

	mstt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.operation    (req.operation),
		.client_id    (req.client_id),
		.period_ticks (req.period_ticks),
		.rsp_valid    (rsp.valid),
		.rsp_ready    (rsp.ready),
		.status       (rsp.status),
		.expired      (rsp.expired),
		.expired_id   (rsp.expired_id),
		.expired_slot (rsp.expired_slot),
		.last         (rsp.last)
	);

`ifndef SYNTH
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready && state == mstt_pkg::S_SCAN)
		else $error("request taken while a scan is in progress");

	a_non_last_is_expiry: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.last |-> rsp.expired && rsp.status == mstt_pkg::STS_OK)
		else $error("non-final result is not an expiry report");

	a_empty_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.expired |-> rsp.expired_id == '0 && rsp.expired_slot == '0)
		else $error("result without expiry carries slot data");
`endif

endmodule
